[design/tthd_pkg.sv]
package tthd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [1:0] EV_DOWN = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_HOLD = 2'd2;
  localparam logic [1:0] EV_TAP  = 2'd3;

  localparam logic [7:0] CFG_TAP_MAX  = 8'd0;
  localparam logic [7:0] CFG_TAP_GAP  = 8'd1;
  localparam logic [7:0] CFG_HOLD     = 8'd2;
  localparam logic [7:0] CFG_WATCH_EN = 8'd3;

  localparam logic [15:0] RST_TAP_MAX = 16'd40;
  localparam logic [15:0] RST_TAP_GAP = 16'd30;
  localparam logic [15:0] RST_HOLD    = 16'd80;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] tap_count;
    logic       match_request;
    logic       last_event;
  } evt_t;

  typedef struct packed {
    logic [1:0] push_n;
    evt_t       ev0;
    evt_t       ev1;
  } push_t;

endpackage

[design/tthd_core.sv]
module tthd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              touch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output tthd_pkg::push_t   push
);

  logic [15:0] tap_max_r, tap_gap_r, hold_r;
  logic        watch_r;

  logic        prev_r, prev_nxt;
  logic [15:0] press_r, press_nxt;
  logic        hold_rep_r, hold_rep_nxt;
  logic [7:0]  taps_r, taps_nxt;
  logic [15:0] gap_r, gap_nxt;

  logic        rise, fall, prim, tap_ev;
  tthd_pkg::evt_t prim_ev, tap_e;

  always_comb begin
    press_nxt    = (press_r == 16'hFFFF) ? press_r : press_r + 16'd1;
    gap_nxt      = (gap_r == 16'hFFFF) ? gap_r : gap_r + 16'd1;
    hold_rep_nxt = hold_rep_r;
    taps_nxt     = taps_r;
    prev_nxt     = touch;
    rise         = touch & ~prev_r;
    fall         = ~touch & prev_r;
    prim         = 1'b0;
    prim_ev      = '0;
    if (rise) begin
      press_nxt     = 16'd0;
      hold_rep_nxt  = 1'b0;
      prim          = 1'b1;
      prim_ev.event_kind    = tthd_pkg::EV_DOWN;
      prim_ev.match_request = watch_r;
    end else if (fall) begin
      prim               = 1'b1;
      prim_ev.event_kind = tthd_pkg::EV_UP;
      if (!hold_rep_r && press_nxt < tap_max_r) begin
        if (taps_r != 8'hFF) taps_nxt = taps_r + 8'd1;
        gap_nxt = 16'd0;
      end
    end else if (touch && !hold_rep_r && press_nxt >= hold_r) begin
      hold_rep_nxt       = 1'b1;
      taps_nxt           = 8'd0;
      prim               = 1'b1;
      prim_ev.event_kind = tthd_pkg::EV_HOLD;
    end
    tap_ev = (taps_nxt != 8'd0) && !touch && (gap_nxt >= tap_gap_r);
    tap_e  = '0;
    tap_e.event_kind = tthd_pkg::EV_TAP;
    tap_e.tap_count  = taps_nxt;
    tap_e.last_event = 1'b1;
    if (tap_ev) taps_nxt = 8'd0;

    push = '0;
    if (prim) begin
      push.ev0 = prim_ev;
      push.ev0.last_event = ~tap_ev;
      push.ev1 = tap_e;
      push.push_n = tap_ev ? 2'd2 : 2'd1;
    end else if (tap_ev) begin
      push.ev0    = tap_e;
      push.push_n = 2'd1;
    end
    if (!fire) push.push_n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_max_r  <= tthd_pkg::RST_TAP_MAX;
      tap_gap_r  <= tthd_pkg::RST_TAP_GAP;
      hold_r     <= tthd_pkg::RST_HOLD;
      watch_r    <= 1'b0;
      prev_r     <= 1'b0;
      press_r    <= 16'd0;
      hold_rep_r <= 1'b0;
      taps_r     <= 8'd0;
      gap_r      <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tthd_pkg::CFG_TAP_MAX:  tap_max_r <= cfg_data;
          tthd_pkg::CFG_TAP_GAP:  tap_gap_r <= cfg_data;
          tthd_pkg::CFG_HOLD:     hold_r    <= cfg_data;
          tthd_pkg::CFG_WATCH_EN: watch_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (fire) begin
        prev_r     <= prev_nxt;
        press_r    <= press_nxt;
        hold_rep_r <= hold_rep_nxt;
        taps_r     <= taps_nxt;
        gap_r      <= gap_nxt;
      end
    end
  end

endmodule

[design/tthd_fifo.sv]
module tthd_fifo #(
  parameter int unsigned DEPTH = tthd_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tthd_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output tthd_pkg::evt_t  head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tthd_pkg::evt_t mem [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, wr1, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    pop     = out_valid & ~out_stall;
    wr1     = step(wr_r);
    wr_nxt  = (push.push_n == 2'd2) ? step(wr1) : (push.push_n == 2'd1) ? wr1 : wr_r;
    rd_nxt  = pop ? step(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.push_n) - CW'(pop);
  end

  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign head      = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push.push_n != 2'd0) mem[wr_r] <= push.ev0;
    if (push.push_n == 2'd2) mem[wr1]  <= push.ev1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/touch_tap_hold_detector_unit.sv]
// A tick's results are written into the result queue when the tick is transferred in.
// Throughput: one tick per cycle while the queue has room; a tick yields zero, one or two results,
// drained one per cycle, unless out_stall holds them, through a result queue of FIFO_DEPTH entries.
// Input stalls while the queue lacks room for two results.
// Reset (rst_n low, synchronous) restores register defaults, clears state and empties the queue.
module touch_tap_hold_detector_unit #(
  parameter int unsigned FIFO_DEPTH = tthd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_touch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_tap_count,
  output logic        out_match_request,
  output logic        out_last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tthd_pkg::push_t push;
  tthd_pkg::evt_t  head;
  logic            room, fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~room;
  assign fire      = in_valid & room;

  tthd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .touch        (in_touch),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push)
  );

  tthd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign out_event_kind    = head.event_kind;
  assign out_tap_count     = head.tap_count;
  assign out_match_request = head.match_request;
  assign out_last_event    = head.last_event;

endmodule

[design/tthd_checker.sv]
module tthd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_event_kind,
  input logic [7:0] out_tap_count,
  input logic       out_match_request,
  input logic       out_last_event
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_event_kind) && $stable(out_tap_count))
    else $error("stalled result changed");

  a_count_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != tthd_pkg::EV_TAP |-> out_tap_count == 8'd0)
    else $error("tap count on non-tap result");

  a_match_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_request |-> out_event_kind == tthd_pkg::EV_DOWN)
    else $error("match request on non-down result");

  a_tap_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == tthd_pkg::EV_TAP |-> out_last_event && out_tap_count != 8'd0)
    else $error("tap report malformed");

endmodule

bind touch_tap_hold_detector_unit tthd_checker u_tthd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_kind   (out_event_kind),
  .out_tap_count    (out_tap_count),
  .out_match_request(out_match_request),
  .out_last_event   (out_last_event)
);
